// File: rtl/core/dewd_pkg.sv
// Shared types, constants and helper functions of the detector event word decoder.
package dewd_pkg;

   localparam int WORD_BITS = 24;
   localparam int FLD_BITS  = 11;
   localparam int OUT_BITS  = WORD_BITS + 1;
   localparam int TIME_BITS = 64;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   // Bit layout of a field descriptor register.
   localparam int FLD_EN_BIT  = 10;
   localparam int FLD_LEN_MSB = 9;
   localparam int FLD_LEN_LSB = 5;
   localparam int FLD_POS_MSB = 4;
   localparam int FLD_POS_LSB = 0;

   // Division by six as a multiply by a rounded-up reciprocal and a shift.
   localparam int DIV6_SHIFT = WORD_BITS + 2;
   localparam longint DIV6_MULT_L = ((longint'(1) <<< DIV6_SHIFT) + 5) / 6;
   localparam logic [WORD_BITS-1:0] DIV6_MULT = WORD_BITS'(DIV6_MULT_L);
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam logic [7:0] ANODE_UNKNOWN = 8'd255;
   localparam logic [7:0] ANODE_PROPANE = 8'd40;
   localparam logic [7:0] ANODE_TABLE [6] = '{8'd10, 8'd11, 8'd20, 8'd21, 8'd30, 8'd31};

   localparam logic signed [OUT_BITS-1:0] NULL_DEFAULT = OUT_BITS'(255);
   localparam logic signed [OUT_BITS-1:0] NULL_FLAGGED = -OUT_BITS'(999);

   typedef enum logic [2:0] {
      CSR_EVENT_MASK     = 3'd0,
      CSR_CHANNEL_FIELD  = 3'd1,
      CSR_DETECTOR_FIELD = 3'd2,
      CSR_ANODE_FIELD    = 3'd3,
      CSR_COMBINED_FIELD = 3'd4,
      CSR_PROPANE_FIELD  = 3'd5,
      CSR_NULL_STYLE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] event_mask;
      logic [FLD_BITS-1:0]  channel_field;
      logic [FLD_BITS-1:0]  detector_field;
      logic [FLD_BITS-1:0]  anode_onehot_field;
      logic [FLD_BITS-1:0]  combined_field;
      logic [FLD_BITS-1:0]  propane_field;
      logic                 null_style;
   } cfg_type;

   // Pulls one bit field out of the word; bits past the word read as zero.
   function automatic logic [WORD_BITS-1:0] fld_extract(
      input logic [WORD_BITS-1:0] word,
      input logic [FLD_BITS-1:0]  fld
   );
      logic [WORD_BITS-1:0] shifted;
      logic [31:0]          mask;
      shifted = word >> fld[FLD_POS_MSB:FLD_POS_LSB];
      mask    = (32'd1 << fld[FLD_LEN_MSB:FLD_LEN_LSB]) - 32'd1;
      return shifted & mask[WORD_BITS-1:0];
   endfunction

   function automatic logic [7:0] onehot_code(input logic [WORD_BITS-1:0] v);
      logic [7:0] code;
      case (v)
         WORD_BITS'(1):  code = ANODE_TABLE[0];
         WORD_BITS'(2):  code = ANODE_TABLE[1];
         WORD_BITS'(4):  code = ANODE_TABLE[2];
         WORD_BITS'(8):  code = ANODE_TABLE[3];
         WORD_BITS'(16): code = ANODE_TABLE[4];
         WORD_BITS'(32): code = ANODE_TABLE[5];
         default:        code = ANODE_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/core/dewd_csr.sv
// Configuration register file of the detector event word decoder.
module dewd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dewd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [dewd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [dewd_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output dewd_pkg::cfg_type                     cfg
);

   dewd_pkg::cfg_type       cfg_ff;
   dewd_pkg::cfg_type       cfg_in;
   dewd_pkg::csr_index_type index;
   logic                    wr_en;

   assign index      = dewd_pkg::csr_index_type'(csr_paddr[dewd_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            dewd_pkg::CSR_EVENT_MASK:
               cfg_in.event_mask = csr_pwdata[dewd_pkg::WORD_BITS-1:0];
            dewd_pkg::CSR_CHANNEL_FIELD:
               cfg_in.channel_field = csr_pwdata[dewd_pkg::FLD_BITS-1:0];
            dewd_pkg::CSR_DETECTOR_FIELD:
               cfg_in.detector_field = csr_pwdata[dewd_pkg::FLD_BITS-1:0];
            dewd_pkg::CSR_ANODE_FIELD:
               cfg_in.anode_onehot_field = csr_pwdata[dewd_pkg::FLD_BITS-1:0];
            dewd_pkg::CSR_COMBINED_FIELD:
               cfg_in.combined_field = csr_pwdata[dewd_pkg::FLD_BITS-1:0];
            dewd_pkg::CSR_PROPANE_FIELD:
               cfg_in.propane_field = csr_pwdata[dewd_pkg::FLD_BITS-1:0];
            dewd_pkg::CSR_NULL_STYLE:
               cfg_in.null_style = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         dewd_pkg::CSR_EVENT_MASK:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.event_mask);
         dewd_pkg::CSR_CHANNEL_FIELD:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.channel_field);
         dewd_pkg::CSR_DETECTOR_FIELD:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.detector_field);
         dewd_pkg::CSR_ANODE_FIELD:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.anode_onehot_field);
         dewd_pkg::CSR_COMBINED_FIELD:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.combined_field);
         dewd_pkg::CSR_PROPANE_FIELD:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.propane_field);
         dewd_pkg::CSR_NULL_STYLE:
            csr_prdata = dewd_pkg::CSR_DATA_BITS'(cfg_ff.null_style);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/detector_event_word_decoder.sv
// Top level of the detector event word decoder: register file and three-stage decode pipeline.
//
// Items enter on the req_ channel (timestamp and raw event word) and leave on the
// rsp_ channel, both valid/ready. An item whose word ANDed with event_mask is zero
// is dropped at the first stage and gives no result; every other item gives one.
// An item passes three register stages before rsp_valid rises: stage one registers
// the extracted bit fields, stage two registers the one-hot anode code and the product
// of the combined field with the reciprocal of six, and stage three forms the
// quotient, remainder and final field selection into the output register.
// Throughput is one item per cycle while the receiver keeps rsp_ready high; the 24 by
// 24 bit reciprocal multiplier sets the depth of the middle stage. When the receiver
// holds rsp_ready low the stages fill from the output backward and req_ready falls
// once all three are full; no item is lost or repeated. Synchronous reset empties the
// pipeline and clears all configuration registers to zero. The user must write the
// configuration through the csr_ port only while no item is in flight; the block does
// not enforce this. pready is always high.
module detector_event_word_decoder (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [dewd_pkg::TIME_BITS-1:0]             req_event_time,
   input  logic [dewd_pkg::WORD_BITS-1:0]             req_event_word,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [dewd_pkg::TIME_BITS-1:0]             rsp_out_time,
   output logic [dewd_pkg::WORD_BITS-1:0]             rsp_out_word,
   output logic signed [dewd_pkg::OUT_BITS-1:0]       rsp_detector_id,
   output logic [7:0]                                 rsp_anode_id,
   output logic signed [dewd_pkg::OUT_BITS-1:0]       rsp_pulse_height,
   output logic [dewd_pkg::WORD_BITS-1:0]             rsp_propane_hit,
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [dewd_pkg::CSR_ADDR_BITS-1:0]         csr_paddr,
   input  logic [dewd_pkg::CSR_DATA_BITS-1:0]         csr_pwdata,
   output logic [dewd_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                       csr_pready
);

   localparam int W = dewd_pkg::WORD_BITS;
   localparam int O = dewd_pkg::OUT_BITS;
   localparam int T = dewd_pkg::TIME_BITS;
   localparam int P = dewd_pkg::PROD_BITS;
   localparam int S = dewd_pkg::DIV6_SHIFT;
   localparam int E = dewd_pkg::FLD_EN_BIT;

   dewd_pkg::cfg_type cfg;

   dewd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stage registers.
   logic         s1_valid_ff, s1_valid_in;
   logic [T-1:0] s1_time_ff;
   logic [W-1:0] s1_word_ff, s1_det_ff, s1_onehot_ff, s1_chan_ff, s1_comb_ff, s1_prop_ff;

   logic         s2_valid_ff, s2_valid_in;
   logic [T-1:0] s2_time_ff;
   logic [W-1:0] s2_word_ff, s2_det_ff, s2_chan_ff, s2_comb_ff, s2_prop_ff;
   logic [7:0]   s2_anode_ff;
   logic [P-1:0] s2_prod_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [T-1:0] rsp_time_ff;
   logic [W-1:0] rsp_word_ff, rsp_prop_ff;
   logic [O-1:0] rsp_det_ff, rsp_det_in, rsp_pha_ff, rsp_pha_in;
   logic [7:0]   rsp_anode_ff, rsp_anode_in;

   logic         s1_ready, s2_ready, s3_ready;
   logic         req_fire, keep;

   logic [W-1:0] quot;
   logic [W-1:0] quot6;
   logic [2:0]   rem;
   logic [O-1:0] null_value;

   assign s3_ready  = ~rsp_valid_ff | rsp_ready;
   assign s2_ready  = ~s2_valid_ff | s3_ready;
   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid & s1_ready;
   assign keep      = (req_event_word & cfg.event_mask) != '0;

   assign s1_valid_in  = s1_ready ? (req_fire & keep) : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = s3_ready ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage one: bit field extraction. A disabled propane field is zeroed here.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_time_ff   <= req_event_time;
         s1_word_ff   <= req_event_word;
         s1_det_ff    <= dewd_pkg::fld_extract(req_event_word, cfg.detector_field);
         s1_onehot_ff <= dewd_pkg::fld_extract(req_event_word, cfg.anode_onehot_field);
         s1_chan_ff   <= dewd_pkg::fld_extract(req_event_word, cfg.channel_field);
         s1_comb_ff   <= dewd_pkg::fld_extract(req_event_word, cfg.combined_field);
         s1_prop_ff   <= cfg.propane_field[E] ?
                         dewd_pkg::fld_extract(req_event_word, cfg.propane_field) : '0;
      end
   end

   // Stage two: one-hot anode code and reciprocal multiply of the combined field.
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_time_ff  <= s1_time_ff;
         s2_word_ff  <= s1_word_ff;
         s2_det_ff   <= s1_det_ff;
         s2_chan_ff  <= s1_chan_ff;
         s2_comb_ff  <= s1_comb_ff;
         s2_prop_ff  <= s1_prop_ff;
         s2_anode_ff <= cfg.anode_onehot_field[E] ?
                        dewd_pkg::onehot_code(s1_onehot_ff) : dewd_pkg::ANODE_UNKNOWN;
         s2_prod_ff  <= P'(s1_comb_ff) * P'(dewd_pkg::DIV6_MULT);
      end
   end

   // Stage three: quotient and remainder by six, then the field priority.
   assign quot  = W'(s2_prod_ff[P-1:S]);
   assign quot6 = (quot << 2) + (quot << 1);
   assign rem   = 3'(s2_comb_ff - quot6);
   assign null_value = cfg.null_style ? dewd_pkg::NULL_FLAGGED : dewd_pkg::NULL_DEFAULT;

   always_comb begin
      rsp_det_in   = null_value;
      rsp_anode_in = s2_anode_ff;
      if (cfg.detector_field[E]) begin
         rsp_det_in = O'(s2_det_ff);
      end
      if (cfg.combined_field[E]) begin
         rsp_det_in = O'(quot);
         case (rem)
            3'd0:    rsp_anode_in = dewd_pkg::ANODE_TABLE[0];
            3'd1:    rsp_anode_in = dewd_pkg::ANODE_TABLE[1];
            3'd2:    rsp_anode_in = dewd_pkg::ANODE_TABLE[2];
            3'd3:    rsp_anode_in = dewd_pkg::ANODE_TABLE[3];
            3'd4:    rsp_anode_in = dewd_pkg::ANODE_TABLE[4];
            3'd5:    rsp_anode_in = dewd_pkg::ANODE_TABLE[5];
            default: rsp_anode_in = dewd_pkg::ANODE_UNKNOWN;
         endcase
      end
      if (s2_prop_ff != '0) begin
         rsp_anode_in = dewd_pkg::ANODE_PROPANE;
      end
      rsp_pha_in = cfg.channel_field[E] ? O'(s2_chan_ff) : null_value;
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         rsp_time_ff  <= s2_time_ff;
         rsp_word_ff  <= s2_word_ff;
         rsp_prop_ff  <= s2_prop_ff;
         rsp_det_ff   <= rsp_det_in;
         rsp_anode_ff <= rsp_anode_in;
         rsp_pha_ff   <= rsp_pha_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_time     = rsp_time_ff;
   assign rsp_out_word     = rsp_word_ff;
   assign rsp_detector_id  = rsp_det_ff;
   assign rsp_anode_id     = rsp_anode_ff;
   assign rsp_pulse_height = rsp_pha_ff;
   assign rsp_propane_hit  = rsp_prop_ff;

   // A dropped item never occupies the first stage.
   a_drop_masked: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !keep) |=> !s1_valid_ff)
      else $error("masked item entered the pipeline");

   // A held middle stage keeps its item.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> (s2_valid_ff && $stable(s2_word_ff)))
      else $error("stalled middle stage lost its item");

   // The propane code appears only with a nonzero propane value.
   a_propane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_anode_ff == dewd_pkg::ANODE_PROPANE) |-> (rsp_prop_ff != '0))
      else $error("propane anode code without propane hit");

   // The combined remainder is always below six.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (rem < 3'd6))
      else $error("combined field remainder out of range");

endmodule

// File: tb/dewd_event_checker.sv
`timescale 1ns / 100ps
// Checker for the event word decoder: follows register traffic, predicts and compares results.
module dewd_event_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [dewd_pkg::TIME_BITS-1:0]       req_event_time,
   input  logic [dewd_pkg::WORD_BITS-1:0]       req_event_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [dewd_pkg::TIME_BITS-1:0]       rsp_out_time,
   input  logic [dewd_pkg::WORD_BITS-1:0]       rsp_out_word,
   input  logic signed [dewd_pkg::OUT_BITS-1:0] rsp_detector_id,
   input  logic [7:0]                           rsp_anode_id,
   input  logic signed [dewd_pkg::OUT_BITS-1:0] rsp_pulse_height,
   input  logic [dewd_pkg::WORD_BITS-1:0]       rsp_propane_hit,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dewd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dewd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input  logic [dewd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input  logic                                 csr_pready,
   output int                                   fail_count,
   output int                                   outstanding
);

   localparam int WB = dewd_pkg::WORD_BITS;
   localparam int OB = dewd_pkg::OUT_BITS;
   localparam int ANODE_SLOTS = 6;
   localparam logic [63:0] COMBINED_DIV = 64'(ANODE_SLOTS);

   localparam logic [7:0] ANODE_L1      = 8'd10;
   localparam logic [7:0] ANODE_R1      = 8'd11;
   localparam logic [7:0] ANODE_L2      = 8'd20;
   localparam logic [7:0] ANODE_R2      = 8'd21;
   localparam logic [7:0] ANODE_L3      = 8'd30;
   localparam logic [7:0] ANODE_R3      = 8'd31;
   localparam logic [7:0] ANODE_PROP    = 8'd40;
   localparam logic [7:0] ANODE_NONE    = 8'd255;
   localparam logic [OB-1:0] PLAIN_NULL   = OB'(255);
   localparam logic [OB-1:0] FLAGGED_NULL = -OB'(999);

   typedef struct packed {
      logic [dewd_pkg::TIME_BITS-1:0] stamp;
      logic [WB-1:0]                  word;
      logic [OB-1:0]                  detector;
      logic [7:0]                     anode;
      logic [OB-1:0]                  pulse;
      logic [WB-1:0]                  propane;
   } decoded_event_type;

   dewd_pkg::cfg_type cfg;
   decoded_event_type expected_q[$];
   decoded_event_type want;
   int                errors = 0;
   int                waiting = 0;

   assign fail_count  = errors;
   assign outstanding = waiting;

   // Descriptor layout: enable at bit 10, length in bits 9:5, position in bits 4:0.
   function automatic logic [63:0] field_bits(input logic [10:0] fld, input logic [WB-1:0] word);
      logic [63:0] wide;
      logic [63:0] keep;
      wide = 64'(word) >> fld[4:0];
      keep = (64'd1 << fld[9:5]) - 64'd1;
      return wide & keep;
   endfunction

   function automatic logic [7:0] slot_anode(input logic [63:0] slot);
      logic [7:0] code;
      case (slot)
         64'd0:   code = ANODE_L1;
         64'd1:   code = ANODE_R1;
         64'd2:   code = ANODE_L2;
         64'd3:   code = ANODE_R2;
         64'd4:   code = ANODE_L3;
         64'd5:   code = ANODE_R3;
         default: code = ANODE_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] onehot_anode(input logic [63:0] v);
      logic [7:0] code;
      code = ANODE_NONE;
      for (int k = 0; k < ANODE_SLOTS; k++) begin
         if (v == (64'd1 << k)) begin
            code = slot_anode(64'(k));
         end
      end
      return code;
   endfunction

   // Later fields override earlier ones: detector, anode, channel, combined, propane.
   function automatic decoded_event_type predict_event(input logic [63:0] stamp,
                                                       input logic [WB-1:0] word);
      decoded_event_type ev;
      logic [63:0]       v;
      logic [63:0]       prop;
      ev.stamp    = stamp;
      ev.word     = word;
      ev.detector = cfg.null_style ? FLAGGED_NULL : PLAIN_NULL;
      ev.pulse    = ev.detector;
      ev.anode    = ANODE_NONE;
      prop        = '0;
      if (cfg.detector_field[10]) begin
         v = field_bits(cfg.detector_field, word);
         ev.detector = v[OB-1:0];
      end
      if (cfg.anode_onehot_field[10]) begin
         ev.anode = onehot_anode(field_bits(cfg.anode_onehot_field, word));
      end
      if (cfg.channel_field[10]) begin
         v = field_bits(cfg.channel_field, word);
         ev.pulse = v[OB-1:0];
      end
      if (cfg.combined_field[10]) begin
         v = field_bits(cfg.combined_field, word);
         ev.detector = OB'(v / COMBINED_DIV);
         ev.anode    = slot_anode(v % COMBINED_DIV);
      end
      if (cfg.propane_field[10]) begin
         prop = field_bits(cfg.propane_field, word);
      end
      if (prop != 0) begin
         ev.anode = ANODE_PROP;
      end
      ev.propane = prop[WB-1:0];
      return ev;
   endfunction

   function automatic logic [31:0] register_value(input logic [dewd_pkg::CSR_ADDR_BITS-1:0] addr);
      logic [31:0] value;
      case (dewd_pkg::csr_index_type'(addr[4:2]))
         dewd_pkg::CSR_EVENT_MASK:     value = 32'(cfg.event_mask);
         dewd_pkg::CSR_CHANNEL_FIELD:  value = 32'(cfg.channel_field);
         dewd_pkg::CSR_DETECTOR_FIELD: value = 32'(cfg.detector_field);
         dewd_pkg::CSR_ANODE_FIELD:    value = 32'(cfg.anode_onehot_field);
         dewd_pkg::CSR_COMBINED_FIELD: value = 32'(cfg.combined_field);
         dewd_pkg::CSR_PROPANE_FIELD:  value = 32'(cfg.propane_field);
         dewd_pkg::CSR_NULL_STYLE:     value = 32'(cfg.null_style);
         default:                      value = '0;
      endcase
      return value;
   endfunction

   task automatic store_register(input logic [dewd_pkg::CSR_ADDR_BITS-1:0] addr,
                                 input logic [31:0] data);
      case (dewd_pkg::csr_index_type'(addr[4:2]))
         dewd_pkg::CSR_EVENT_MASK:     cfg.event_mask         = data[WB-1:0];
         dewd_pkg::CSR_CHANNEL_FIELD:  cfg.channel_field      = data[10:0];
         dewd_pkg::CSR_DETECTOR_FIELD: cfg.detector_field     = data[10:0];
         dewd_pkg::CSR_ANODE_FIELD:    cfg.anode_onehot_field = data[10:0];
         dewd_pkg::CSR_COMBINED_FIELD: cfg.combined_field     = data[10:0];
         dewd_pkg::CSR_PROPANE_FIELD:  cfg.propane_field      = data[10:0];
         dewd_pkg::CSR_NULL_STYLE:     cfg.null_style         = data[0];
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               store_register(csr_paddr, csr_pwdata);
            end else begin
               compare_field("register readback", 64'(register_value(csr_paddr)),
                             64'(csr_prdata));
            end
         end
         if (req_valid && req_ready && (req_event_word & cfg.event_mask) != '0) begin
            expected_q.push_back(predict_event(req_event_time, req_event_word));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: result with no item waiting, expected none, actual word %h",
                        $time, rsp_out_word);
            end else begin
               want = expected_q.pop_front();
               compare_field("out_time", want.stamp, rsp_out_time);
               compare_field("out_word", 64'(want.word), 64'(rsp_out_word));
               compare_field("detector_id", 64'(want.detector),
                             64'(rsp_detector_id[OB-1:0]));
               compare_field("anode_id", 64'(want.anode), 64'(rsp_anode_id));
               compare_field("pulse_height", 64'(want.pulse),
                             64'(rsp_pulse_height[OB-1:0]));
               compare_field("propane_hit", 64'(want.propane), 64'(rsp_propane_hit));
            end
         end
      end
      waiting = expected_q.size();
   end

endmodule

// File: tb/tb_detector_event_word_decoder.sv
`timescale 1ns / 100ps
// Testbench top for the event word decoder: clock, reset, item and register stimulus, verdict.
module tb_detector_event_word_decoder;

   localparam int RESET_CYCLES    = 11;
   localparam int DRAIN_CYCLES    = 8;
   localparam int LONG_HOLD       = 48;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int TIMEOUT_NS      = 3_000_000;
   localparam int WB              = dewd_pkg::WORD_BITS;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic [dewd_pkg::TIME_BITS-1:0]       req_event_time;
   logic [WB-1:0]                        req_event_word;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [dewd_pkg::TIME_BITS-1:0]       rsp_out_time;
   logic [WB-1:0]                        rsp_out_word;
   logic signed [dewd_pkg::OUT_BITS-1:0] rsp_detector_id;
   logic [7:0]                           rsp_anode_id;
   logic signed [dewd_pkg::OUT_BITS-1:0] rsp_pulse_height;
   logic [WB-1:0]                        rsp_propane_hit;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [dewd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [dewd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [dewd_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                 csr_pready;
   int                                   fail_count;
   int                                   outstanding;

   logic          tx_calm = 1'b0;
   logic          rx_calm = 1'b0;
   logic          hold_request = 1'b0;
   logic [WB-1:0] cur_mask;
   logic [10:0]   cur_anode;
   logic [10:0]   cur_prop;

   detector_event_word_decoder u_top (.*);

   dewd_event_checker u_check (.*);

   always #5 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [10:0] fld_desc(input logic en, input int len, input int pos);
      return {en, 5'(len), 5'(pos)};
   endfunction

   function automatic logic [10:0] pick_field();
      logic [10:0] f;
      case ($urandom_range(0, 9))
         0:       f = '0;
         1:       f = 11'h7FF;
         2:       f = fld_desc(1'b1, 0, 0);
         3:       f = fld_desc(1'b0, $urandom_range(0, 31), $urandom_range(0, 31));
         4:       f = fld_desc(1'b1, $urandom_range(0, 31), $urandom_range(0, 31));
         default: f = fld_desc(1'b1, $urandom_range(1, 8), $urandom_range(0, WB - 1));
      endcase
      return f;
   endfunction

   function automatic logic [WB-1:0] pick_mask();
      logic [WB-1:0] m;
      case ($urandom_range(0, 3))
         0:       m = '1;
         1:       m = WB'(1) << $urandom_range(0, WB - 1);
         default: m = WB'($urandom);
      endcase
      return m;
   endfunction

   // Writes v into the bit field that fld describes; bits past the word are lost.
   function automatic logic [WB-1:0] place_field(input logic [WB-1:0] w, input logic [10:0] fld,
                                                 input logic [63:0] v);
      logic [63:0] keep;
      logic [63:0] wide;
      keep = ((64'd1 << fld[9:5]) - 64'd1) << fld[4:0];
      wide = (64'(w) & ~keep) | ((v << fld[4:0]) & keep);
      return wide[WB-1:0];
   endfunction

   // Random words, biased toward valid one-hot anodes and a clear propane field so that
   // the anode decode is reached often; a few words miss the mask and are dropped.
   function automatic logic [WB-1:0] shape_word();
      logic [WB-1:0] w;
      w = WB'($urandom);
      if (cur_anode[10] && $urandom_range(0, 1) == 1) begin
         w = place_field(w, cur_anode, 64'd1 << $urandom_range(0, 5));
      end
      if (cur_prop[10] && $urandom_range(0, 2) == 0) begin
         w = place_field(w, cur_prop, 64'd0);
      end
      if ($urandom_range(0, 7) == 0) begin
         w = w & ~cur_mask;
      end
      return w;
   endfunction

   task automatic send_event(input logic [63:0] stamp, input logic [WB-1:0] word);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_event_time <= stamp;
      req_event_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Dropped items leave no trace in the checker, so a few extra cycles cover them.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input dewd_pkg::csr_index_type idx,
                             input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic load_registers(input logic [WB-1:0] mask,
                                 input logic [10:0] chan, det, anode, comb, prop,
                                 input logic style);
      dewd_pkg::csr_index_type idx;
      settle();
      cur_mask  = mask;
      cur_anode = anode;
      cur_prop  = prop;
      csr_access(1'b1, dewd_pkg::CSR_EVENT_MASK, 32'(mask));
      csr_access(1'b1, dewd_pkg::CSR_CHANNEL_FIELD, 32'(chan));
      csr_access(1'b1, dewd_pkg::CSR_DETECTOR_FIELD, 32'(det));
      csr_access(1'b1, dewd_pkg::CSR_ANODE_FIELD, 32'(anode));
      csr_access(1'b1, dewd_pkg::CSR_COMBINED_FIELD, 32'(comb));
      csr_access(1'b1, dewd_pkg::CSR_PROPANE_FIELD, 32'(prop));
      csr_access(1'b1, dewd_pkg::CSR_NULL_STYLE, 32'(style));
      idx = idx.first();
      repeat (idx.num()) begin
         csr_access(1'b0, idx, '0);
         idx = idx.next();
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side: a random stall before each item, calm stretches, and a long hold on request.
   initial begin
      int stall;
      int taken;
      rsp_ready = 1'b0;
      taken     = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            stall        = LONG_HOLD;
            hold_request = 1'b0;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 40 == 0) begin
            rx_calm = ($urandom_range(0, 2) == 0);
         end
         @(negedge clock);
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_event_time = '0;
      req_event_word = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Separate fields: every one-hot anode, non one-hot values, propane override.
      load_registers('1, fld_desc(1'b1, 8, 0), fld_desc(1'b1, 4, 8), fld_desc(1'b1, 6, 12),
                     '0, fld_desc(1'b1, 6, 18), 1'b0);
      for (int k = 0; k < 6; k++) begin
         send_event(64'(k), {6'd0, 6'd1 << k, 4'(k), 8'(37 * k)});
      end
      send_event('1, {6'd0, 6'd0, 4'hF, 8'hFF});
      send_event({$urandom, $urandom}, {6'd0, 6'd3, 4'h5, 8'h80});
      send_event({$urandom, $urandom}, {6'd5, 6'd4, 4'hA, 8'h01});
      send_event('1, '1);
      send_event('0, '0);

      // Combined field over the whole word: every remainder, largest quotient.
      load_registers(24'h800001, '0, fld_desc(1'b1, 4, 0), '0, fld_desc(1'b1, WB, 0), '0,
                     1'b1);
      for (int k = 0; k < 6; k++) begin
         send_event({$urandom, $urandom}, 24'h800000 + WB'(k));
      end
      send_event('1, '1);
      send_event({$urandom, $urandom}, 24'h000002);
      send_event({$urandom, $urandom}, 24'h000001);

      // Zero length, maximum length and fields placed past the word.
      load_registers('1, fld_desc(1'b1, 31, 0), fld_desc(1'b1, 0, 5), fld_desc(1'b1, 6, 25),
                     11'h7FF, fld_desc(1'b1, 31, 31), 1'b1);
      send_event({$urandom, $urandom}, '1);
      send_event({$urandom, $urandom}, 24'h5A5A5A);

      // An empty mask drops everything.
      load_registers('0, '0, '0, '0, '0, '0, 1'b0);
      send_event({$urandom, $urandom}, '1);
      send_event({$urandom, $urandom}, WB'($urandom));

      // All fields off: null values only.
      load_registers(24'h000001, '0, '0, '0, '0, '0, 1'b0);
      send_event({$urandom, $urandom}, 24'h000001);
      send_event({$urandom, $urandom}, '1);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            load_registers('1, fld_desc(1'b1, 8, 0), fld_desc(1'b1, 4, 8),
                           fld_desc(1'b1, 6, 12), fld_desc(1'b0, 5, 3),
                           fld_desc(1'b1, 6, 18), 1'($urandom_range(0, 1)));
         end else begin
            load_registers(pick_mask(), pick_field(), pick_field(), pick_field(),
                           pick_field(), pick_field(), 1'($urandom_range(0, 1)));
         end
         // The result side stops for a long stretch while items keep coming.
         if (p % 3 == 0) begin
            hold_request = 1'b1;
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 50 == 0) begin
               tx_calm = ($urandom_range(0, 3) == 0);
            end
            send_event({$urandom, $urandom}, shape_word());
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
